// ----- rtl/lru_key_value_cache_macros.svh -----
// Assertion macros for the port checker of the cache.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Condition a at an edge requires condition b at the same edge.
`define LKVC_ASSERT_IMPLY(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("cache port check failed");

// Condition a at an edge requires condition b at the next edge.
`define LKVC_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("cache port check failed");

`endif

// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants of the key/value cache.
package lkvc_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    MODE_READ  = 1'b0,
    MODE_WRITE = 1'b1
  } mode_t;

  // Decision for the request at the head of the pipeline.
  typedef struct packed {
    logic found;    // key present before this request
    logic write;    // request writes a value
    logic reuse;    // write miss replaces the least recent entry
    logic age_all;  // write miss fills a free entry, every valid entry ages
  } lkvc_ctl_t;

endpackage

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the fully associative key/value cache with LRU replacement.
//
//  channel  | direction | signals                              | payload
//  ---------+-----------+--------------------------------------+--------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser    | key, value / mode
//  m_       | out       | m_tvalid m_tready m_tdata m_tuser    | read_value / found
//  cfg_     | in        | cfg_valid cfg_ready cfg_data         | cache_capacity
//
// One request is taken per cycle unless the output stalls; each result is registered.
// The rate is set by the parallel key compare and rank update over all entries.
// Reset is synchronous and clears the valid bits, occupancy and capacity (to 16) at once.
// A stalled result holds in the output register while one more request waits in the input
// register; only when both are full is s_tready low.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // [31:0] lookup_key, [63:32] store_value
  input  logic [0:0]        s_tuser,   // [0] mode
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // [31:0] read_value
  output logic [0:0]        m_tuser,   // [0] found
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CAP_W-1:0]  cfg_data
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);

  logic              req_valid;
  mode_t             req_mode;
  logic [KEY_W-1:0]  req_key;
  logic [DATA_W-1:0] req_value;

  logic              out_valid;
  logic              out_found;
  logic [DATA_W-1:0] out_value;

  logic [CAP_W-1:0]  capacity;

  logic [ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0]   entry_key [ENTRIES];
  logic [RANK_W-1:0]  entry_rank [ENTRIES];
  logic [OCC_W-1:0]   occupancy;
  logic [DATA_W-1:0]  hit_data;
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] slot_vec;
  logic [RANK_W-1:0]  old_rank;
  lkvc_ctl_t          ctl;
  logic               advance;
  logic [DATA_W-1:0]  read_value;

  assign advance  = req_valid && (!out_valid || m_tready);
  assign s_tready = !req_valid || advance;
  assign cfg_ready = 1'b1;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_found;

  assign read_value = (ctl.found && req_mode == MODE_READ) ? hit_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        req_valid <= 1'b1;
      end else if (advance) begin
        req_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_mode  <= mode_t'(s_tuser[0]);
      req_key   <= s_tdata[31:0];
      req_value <= s_tdata[63:32];
    end
    if (advance) begin
      out_found <= ctl.found;
      out_value <= read_value;
    end
  end

  lkvc_select #(
    .ENTRIES (ENTRIES),
    .RANK_W  (RANK_W),
    .OCC_W   (OCC_W)
  ) u_select (
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_rank  (entry_rank),
    .occupancy   (occupancy),
    .capacity    (capacity),
    .mode        (req_mode),
    .lookup_key  (req_key),
    .hit_vec     (hit_vec),
    .slot_vec    (slot_vec),
    .old_rank    (old_rank),
    .ctl         (ctl)
  );

  lkvc_store #(
    .ENTRIES (ENTRIES),
    .RANK_W  (RANK_W),
    .OCC_W   (OCC_W)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .apply       (advance),
    .ctl         (ctl),
    .hit_vec     (hit_vec),
    .slot_vec    (slot_vec),
    .old_rank    (old_rank),
    .lookup_key  (req_key),
    .store_value (req_value),
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_rank  (entry_rank),
    .occupancy   (occupancy),
    .hit_data    (hit_data)
  );

endmodule

// ----- rtl/lkvc_select.sv -----
// Parallel key match, victim and free slot choice for one request.
module lkvc_select import lkvc_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
  input  logic [ENTRIES-1:0] entry_valid,
  input  logic [KEY_W-1:0]   entry_key [ENTRIES],
  input  logic [RANK_W-1:0]  entry_rank [ENTRIES],
  input  logic [OCC_W-1:0]   occupancy,
  input  logic [CAP_W-1:0]   capacity,
  input  mode_t              mode,
  input  logic [KEY_W-1:0]   lookup_key,
  output logic [ENTRIES-1:0] hit_vec,
  output logic [ENTRIES-1:0] slot_vec,
  output logic [RANK_W-1:0]  old_rank,
  output lkvc_ctl_t          ctl
);

  localparam int CMP_W = ((OCC_W > CAP_W) ? OCC_W : CAP_W) + 1;

  logic [ENTRIES-1:0] victim_vec;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] empty_vec;
  logic [OCC_W-1:0]   occ_m1;
  logic [CMP_W-1:0]   occ_ext;
  logic [CMP_W-1:0]   cap_eff;
  logic               full;

  assign occ_m1    = occupancy - OCC_W'(1);
  assign empty_vec = ~entry_valid;
  // Lowest set bit of the empty vector picks the lowest-numbered free entry.
  assign free_vec  = empty_vec & (~empty_vec + ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]    = entry_valid[i] && (entry_key[i] == lookup_key);
      // Ranks of valid entries are always a permutation of 0..occupancy-1.
      victim_vec[i] = entry_valid[i] && (entry_rank[i] == RANK_W'(occ_m1));
    end
  end

  always_comb begin
    occ_ext = CMP_W'(occupancy);
    cap_eff = (capacity == '0) ? CMP_W'(1) : CMP_W'(capacity);
    full    = (occ_ext >= CMP_W'(ENTRIES)) || (occ_ext >= cap_eff);
  end

  always_comb begin
    ctl.found   = |hit_vec;
    ctl.write   = (mode == MODE_WRITE);
    ctl.reuse   = !ctl.found && ctl.write && full;
    ctl.age_all = !ctl.found && ctl.write && !full;
    if (ctl.found) begin
      slot_vec = hit_vec;
    end else if (ctl.reuse) begin
      slot_vec = victim_vec;
    end else begin
      slot_vec = free_vec;
    end
  end

  always_comb begin
    old_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      old_rank = old_rank | (slot_vec[i] ? entry_rank[i] : '0);
    end
  end

endmodule

// ----- rtl/lkvc_store.sv -----
// Entry registers of the cache and their update for one request.
module lkvc_store import lkvc_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               apply,
  input  lkvc_ctl_t          ctl,
  input  logic [ENTRIES-1:0] hit_vec,
  input  logic [ENTRIES-1:0] slot_vec,
  input  logic [RANK_W-1:0]  old_rank,
  input  logic [KEY_W-1:0]   lookup_key,
  input  logic [DATA_W-1:0]  store_value,
  output logic [ENTRIES-1:0] entry_valid,
  output logic [KEY_W-1:0]   entry_key [ENTRIES],
  output logic [RANK_W-1:0]  entry_rank [ENTRIES],
  output logic [OCC_W-1:0]   occupancy,
  output logic [DATA_W-1:0]  hit_data
);

  logic [DATA_W-1:0] entry_data [ENTRIES];
  logic              touch;

  assign touch = apply && (ctl.found || ctl.write);

  always_comb begin
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_data = hit_data | (hit_vec[i] ? entry_data[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
    end else if (touch) begin
      entry_valid <= entry_valid | slot_vec;
      if (ctl.age_all) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_vec[i]) begin
          entry_rank[i] <= '0;
          if (ctl.write) begin
            entry_data[i] <= store_value;
          end
          if (ctl.write && !ctl.found) begin
            entry_key[i] <= lookup_key;
          end
        end else if (entry_valid[i] && (ctl.age_all || entry_rank[i] < old_rank)) begin
          entry_rank[i] <= entry_rank[i] + RANK_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/lkvc_checker.sv -----
// Port-level checks of the cache, bound to the top level.
`include "lru_key_value_cache_macros.svh"

module lkvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // A result that is waiting must not change.
  `LKVC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  // A miss returns zero data (so does every write, which this check does not cover).
  `LKVC_ASSERT_IMPLY(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0)
  // Requests are refused only while a result is waiting on the output side.
  `LKVC_ASSERT_IMPLY(a_stall_cause, !s_tready, m_tvalid)
  // Nothing is offered in the cycle after reset.
  `LKVC_ASSERT_IMPLY(a_reset_empty, $past(rst), !m_tvalid && s_tready)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// ----- tb/sv/lkvc_result_checker.sv -----
`timescale 1ns / 100ps
// Checker for the key/value cache: models the store and compares every returned result.
module lkvc_result_checker import lkvc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [63:0]      s_tdata,   // [31:0] lookup_key, [63:32] store_value
  input  logic [0:0]       s_tuser,   // [0] mode
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [31:0]      m_tdata,   // [31:0] read_value
  input  logic [0:0]       m_tuser,   // [0] found
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int               mismatches,
  output int               outstanding,
  output int               lookups,
  output int               hits,
  output int               evictions
);

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] value;
  } lookup_result_t;

  logic              slot_valid [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [DATA_W-1:0] slot_data  [ENTRIES];
  int unsigned       slot_age   [ENTRIES];
  int unsigned       fill_level;
  logic [CAP_W-1:0]  capacity;
  lookup_result_t    expected_results [$];

  function automatic int unsigned usable_capacity();
    int unsigned c;
    c = 32'(capacity);
    if (c == 0) c = 1;
    if (c > ENTRIES) c = ENTRIES;
    return c;
  endfunction

  // Entry e becomes the most recent; entries that were more recent than it age by one.
  function automatic void promote(int e, bit was_valid);
    int unsigned old_age;
    old_age = was_valid ? slot_age[e] : 32'hFFFF_FFFF;
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != e && slot_valid[i] && slot_age[i] < old_age) slot_age[i]++;
    end
    slot_age[e] = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(mode_t op, logic [KEY_W-1:0] key,
                                                    logic [DATA_W-1:0] value);
    lookup_result_t res;
    int             hit_slot;
    int             slot;
    bit             reuse;
    int unsigned    worst;
    res = '0;
    hit_slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == key) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      res.found = 1'b1;
      if (op == MODE_READ) res.value = slot_data[hit_slot];
      else slot_data[hit_slot] = value;
      promote(hit_slot, 1'b1);
    end else if (op == MODE_WRITE) begin
      reuse = 1'b0;
      slot = 0;
      worst = 0;
      if (fill_level >= usable_capacity() || fill_level >= ENTRIES) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_valid[i] && (!reuse || slot_age[i] > worst)) begin
            worst = slot_age[i];
            slot = i;
            reuse = 1'b1;
          end
        end
      end
      // Without eviction the lowest free entry is taken.
      if (!reuse) begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!slot_valid[i]) slot = i;
        end
      end
      promote(slot, reuse);
      slot_valid[slot] = 1'b1;
      slot_key[slot] = key;
      slot_data[slot] = value;
      if (reuse) evictions++;
      else fill_level++;
    end
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatches < 10)
      $display("%0t: mismatch in %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
    lookups = 0;
    hits = 0;
    evictions = 0;
  end

  always @(posedge clk) begin
    lookup_result_t seen;
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_key[i] = '0;
        slot_data[i] = '0;
        slot_age[i] = 0;
      end
      fill_level = 0;
      capacity = CAP_RESET;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      // A result always belongs to an earlier request, so it is checked before a new
      // request accepted at the same edge is predicted.
      if (m_tvalid && m_tready) begin
        seen.found = m_tuser[0];
        seen.value = m_tdata;
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", '0, seen.value);
        end else begin
          want = expected_results.pop_front();
          if (seen.found !== want.found)
            note_mismatch("found", 32'(want.found), 32'(seen.found));
          if (seen.value !== want.value) note_mismatch("read_value", want.value, seen.value);
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_lookup(mode_t'(s_tuser[0]), s_tdata[31:0], s_tdata[63:32]);
        if (want.found) hits++;
        lookups++;
        expected_results.push_back(want);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the cache testbench: clock, reset, request and result traffic, and the verdict.
module tb_top;
  import lkvc_pkg::*;

  localparam int ENTRIES     = 16;
  localparam int PHASE_ITEMS = 175;
  localparam int LONG_HOLD   = 80;
  localparam int POOL_MAX    = 24;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [63:0]      s_tdata;   // [31:0] lookup_key, [63:32] store_value
  logic [0:0]       s_tuser;   // [0] mode
  logic             m_tvalid;
  logic             m_tready;
  logic [31:0]      m_tdata;   // [31:0] read_value
  logic [0:0]       m_tuser;   // [0] found
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int mismatches;
  int outstanding;
  int lookups;
  int hits;
  int evictions;

  bit calm = 1'b0;        // no idling on either side
  bit sender_gaps = 1'b1;
  bit hold_req = 1'b0;
  int settings_written = 0;

  logic [31:0] key_pool [POOL_MAX];

  lru_key_value_cache #(.ENTRIES(ENTRIES)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lkvc_result_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding), .lookups(lookups),
    .hits(hits), .evictions(evictions)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off when asked for.
  initial begin : result_sink
    int burst;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        m_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 7);
        m_tready = 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_request(input mode_t op, input logic [31:0] key,
                              input logic [31:0] value);
    int gap;
    @(negedge clk);
    if (!calm && sender_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser[0] = op;
    s_tdata = {value, key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering requests and wait until every predicted result has been returned.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (3) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_written++;
  endtask

  // Keys are drawn from a pool a little larger than the capacity so that hits and
  // evictions both happen often.
  task automatic run_phase(input logic [CAP_W-1:0] cap, input bit with_stall);
    int    usable;
    int    pool_size;
    mode_t op;
    logic [31:0] key;
    set_capacity(cap);
    usable = (cap == 0) ? 1 : (int'(cap) > ENTRIES) ? ENTRIES : int'(cap);
    pool_size = usable + $urandom_range(1, 6);
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
    case ($urandom_range(0, 3))
      0: key_pool[0] = 32'h8000_0000;
      1: key_pool[0] = 32'h7FFF_FFFF;
      2: key_pool[0] = 32'hFFFF_FFFF;
      default: key_pool[0] = 32'h0000_0000;
    endcase
    if (with_stall) begin
      hold_req = 1'b1;
      sender_gaps = 1'b0;
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (with_stall && n == 30) sender_gaps = 1'b1;
      op = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
      key = ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, pool_size - 1)];
      send_request(op, key, $urandom);
    end
  endtask

  initial begin : stimulus
    logic [CAP_W-1:0] phase_caps [11];
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    phase_caps = '{5'd5, 5'd8, 5'd31, 5'd3, 5'd16, 5'd1, 5'd12, 5'd17, 5'd0, 5'd7, 5'd16};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Capacity zero behaves as one, starting from an empty store.
    set_capacity(5'd0);
    send_request(MODE_READ,  32'h0000_0000, 32'hFFFF_FFFF);
    send_request(MODE_WRITE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_WRITE, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_READ,  32'h8000_0000, 32'h0000_0000);
    send_request(MODE_READ,  32'h7FFF_FFFF, 32'h0000_0000);
    set_capacity(5'd1);
    send_request(MODE_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_READ,  32'h7FFF_FFFF, 32'h0000_0000);
    send_request(MODE_READ,  32'hFFFF_FFFF, 32'h0000_0000);
    set_capacity(5'd2);
    send_request(MODE_WRITE, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_WRITE, 32'h0000_0001, 32'h0000_0001);
    send_request(MODE_READ,  32'hFFFF_FFFF, 32'h0000_0000);
    send_request(MODE_READ,  32'h0000_0000, 32'h0000_0000);
    send_request(MODE_WRITE, 32'h0000_0000, 32'h1234_5678);
    send_request(MODE_READ,  32'h0000_0000, 32'h0000_0000);
    send_request(MODE_READ,  32'h0000_0001, 32'h0000_0000);

    // The fourth phase lowers the capacity below a full store; the last runs without idling.
    for (int p = 0; p < 11; p++) begin
      if (p == 10) calm = 1'b1;
      run_phase(phase_caps[p], p == 1);
    end

    wait_drained();
    repeat (6) @(posedge clk);
    $display("Summary: %0d requests under %0d capacity settings, %0d hits, %0d evictions;",
             lookups, settings_written, hits, evictions);
    $display("one long result stall and several full drains were included.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
